### src/tpm_pkg.sv
// shared types and constants of the ternary priority match table
`timescale 1ns / 1ps

package tpm_pkg;

    typedef enum logic [2:0] {
        OP_LOOKUP    = 3'd0,
        OP_ADD       = 3'd1,
        OP_DEL_MATCH = 3'd2,
        OP_DEL_ID    = 3'd3,
        OP_CHG_MATCH = 3'd4,
        OP_CHG_ID    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EXISTS  = 2'd1,
        ST_NONE    = 2'd2,
        ST_REFUSED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1
    } rd_sel_t;

    typedef enum logic {
        WA_IDX,
        WA_POS
    } wa_sel_t;

    typedef enum logic [1:0] {
        WD_MOVE,
        WD_NEW,
        WD_TGT
    } wd_sel_t;

    typedef enum logic [1:0] {
        RK_PLAIN,
        RK_HIT,
        RK_MISS,
        RK_ADDED
    } res_kind_t;

    typedef struct packed {
        logic      load;
        logic      idx_clr;
        logic      idx_load_n;
        logic      idx_inc;
        logic      idx_dec;
        logic      pos_from_idx;
        logic      cand_inc;
        logic      ram_re;
        rd_sel_t   rd_sel;
        logic      ram_we;
        wa_sel_t   wa_sel;
        wd_sel_t   wd_sel;
        logic      n_inc;
        logic      n_dec;
        logic      res_load;
        res_kind_t res_kind;
        status_t   res_status;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic req_id_zero;
        logic idx_lt_n;
        logic idx_p1_lt_n;
        logic idx_gt_pos;
        logic full;
        logic lk_match;
        logic mt_eq;
        logic prio_gt;
        logic id_eq;
        logic out_free;
    } stat_t;

    localparam logic CFG_MISS_TARGET = 1'b0;
    localparam logic CFG_KEY_BYTES   = 1'b1;

    localparam logic [30:0] AUTO_ID_BASE    = 31'd1000000;
    localparam logic [3:0]  KEY_BYTES_RESET = 4'd8;
    localparam logic [3:0]  KEY_BYTES_MAX   = 4'd8;

endpackage

### src/tpm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/tpm_datapath.sv
// entry store, scan index, comparators, config and result registers
`timescale 1ns / 1ps

module tpm_datapath #(
    parameter int DEPTH       = 64,
    parameter int KEY_BITS    = 64,
    parameter int TARGET_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tpm_pkg::cmd_t       cmd,
    output tpm_pkg::stat_t      stat,
    input  logic [2:0]          s_op,
    input  logic [KEY_BITS-1:0] s_key,
    input  logic [KEY_BITS-1:0] s_key_mask,
    input  logic [31:0]         s_priority_req,
    input  logic [30:0]         s_entry_id,
    input  logic [31:0]         s_target_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic                m_hit,
    output logic [31:0]         m_target_out,
    output logic [30:0]         m_assigned_id,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int TW = (TARGET_BITS < 32) ? TARGET_BITS : 32;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = 2 * KEY_BITS + 32 + 31 + TW;
    localparam int T_LO = 0;
    localparam int I_LO = TW;
    localparam int P_LO = TW + 31;
    localparam int M_LO = TW + 63;
    localparam int K_LO = TW + 63 + KEY_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    tpm_pkg::op_t      op_reg;
    logic [KEY_BITS-1:0] key_reg, mask_reg;
    logic [31:0]       prio_reg;
    logic [30:0]       id_reg, cand_reg;
    logic [TW-1:0]     tgt_reg;
    logic [CW-1:0]     idx_reg, n_reg, pos_reg;
    logic [31:0]       dflt_reg;
    logic [3:0]        kbytes_reg;

    logic [1:0]        res_status_reg;
    logic              res_hit_reg;
    logic [31:0]       res_tout_reg;
    logic [30:0]       res_aid_reg;

    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic              m_hit_reg;
    logic [31:0]       m_tout_reg;
    logic [30:0]       m_aid_reg;

    logic [WW-1:0]       rdata, wdata;
    logic [AW-1:0]       raddr, waddr;
    logic [KEY_BITS-1:0] e_key, e_mask, cmp_mask;
    logic [31:0]         e_prio;
    logic [30:0]         e_id;
    logic [TW-1:0]       e_tgt;
    logic [3:0]          nbytes;
    logic [CW:0]         idx_p1;
    logic [CW-1:0]       idx_m1;

    assign e_key  = rdata[K_LO +: KEY_BITS];
    assign e_mask = rdata[M_LO +: KEY_BITS];
    assign e_prio = rdata[P_LO +: 32];
    assign e_id   = rdata[I_LO +: 31];
    assign e_tgt  = rdata[T_LO +: TW];

    // compared bits: low key_bytes bytes, larger counts act as eight
    assign nbytes = (kbytes_reg > tpm_pkg::KEY_BYTES_MAX) ? tpm_pkg::KEY_BYTES_MAX : kbytes_reg;

    for (genvar b = 0; b < KEY_BITS; b++) begin : g_cmask
        assign cmp_mask[b] = (4'(b / 8) < nbytes);
    end

    assign idx_p1 = {1'b0, idx_reg} + 1'b1;
    assign idx_m1 = idx_reg - 1'b1;

    always_comb begin
        case (cmd.rd_sel)
            tpm_pkg::RD_IDX_M1: raddr = idx_m1[AW-1:0];
            tpm_pkg::RD_IDX_P1: raddr = idx_p1[AW-1:0];
            default:            raddr = idx_reg[AW-1:0];
        endcase
        waddr = (cmd.wa_sel == tpm_pkg::WA_POS) ? pos_reg[AW-1:0] : idx_reg[AW-1:0];
        case (cmd.wd_sel)
            tpm_pkg::WD_NEW: wdata = {key_reg, mask_reg, prio_reg, cand_reg, tgt_reg};
            tpm_pkg::WD_TGT: wdata = {rdata[WW-1:TW], tgt_reg};
            default:         wdata = rdata;
        endcase
    end

    tpm_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        stat.op          = op_reg;
        stat.req_id_zero = (id_reg == '0);
        stat.idx_lt_n    = (idx_reg < n_reg);
        stat.idx_p1_lt_n = (idx_p1 < {1'b0, n_reg});
        stat.idx_gt_pos  = (idx_reg > pos_reg);
        stat.full        = (n_reg == FULL_COUNT);
        stat.lk_match    = (((e_key ^ key_reg) & e_mask & cmp_mask) == '0);
        stat.mt_eq       = (((e_key ^ key_reg) & cmp_mask) == '0)
                        && (((e_mask ^ mask_reg) & cmp_mask) == '0);
        stat.prio_gt     = (e_prio > prio_reg);
        stat.id_eq       = (e_id == cand_reg);
        stat.out_free    = !m_valid_reg || m_ready;
    end

    // request capture and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= tpm_pkg::op_t'(s_op);
            key_reg  <= s_key;
            mask_reg <= s_key_mask;
            prio_reg <= s_priority_req;
            id_reg   <= s_entry_id;
            tgt_reg  <= s_target_value[TW-1:0];
            cand_reg <= (s_entry_id == '0) ? tpm_pkg::AUTO_ID_BASE : s_entry_id;
        end else if (cmd.cand_inc) begin
            cand_reg <= cand_reg + 1'b1;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_load_n) begin
            idx_reg <= n_reg;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_p1[CW-1:0];
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_m1;
        end
        if (cmd.pos_from_idx) begin
            pos_reg <= idx_reg;
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_hit_reg    <= (cmd.res_kind == tpm_pkg::RK_HIT);
            case (cmd.res_kind)
                tpm_pkg::RK_HIT:  res_tout_reg <= 32'(e_tgt);
                tpm_pkg::RK_MISS: res_tout_reg <= 32'(dflt_reg[TW-1:0]);
                default:          res_tout_reg <= '0;
            endcase
            res_aid_reg <= (cmd.res_kind == tpm_pkg::RK_ADDED) ? cand_reg : '0;
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_hit_reg    <= res_hit_reg;
            m_tout_reg   <= res_tout_reg;
            m_aid_reg    <= res_aid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
            dflt_reg    <= '0;
            kbytes_reg  <= tpm_pkg::KEY_BYTES_RESET;
        end else begin
            if (cmd.n_inc) begin
                n_reg <= n_reg + 1'b1;
            end else if (cmd.n_dec) begin
                n_reg <= n_reg - 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_index == tpm_pkg::CFG_MISS_TARGET) begin
                    dflt_reg <= cfg_data;
                end else if (cfg_index == tpm_pkg::CFG_KEY_BYTES) begin
                    kbytes_reg <= cfg_data[3:0];
                end
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_hit         = m_hit_reg;
    assign m_target_out  = m_tout_reg;
    assign m_assigned_id = m_aid_reg;

endmodule

### src/tpm_ctrl.sv
// sequencer for lookup, add, delete and change scans
`timescale 1ns / 1ps

module tpm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic [2:0]     s_op,
    output logic           s_ready,
    input  tpm_pkg::stat_t stat,
    output tpm_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_CK,
        S_MT_RD,
        S_MT_CK,
        S_ID_RD,
        S_ID_CK,
        S_DEL_RD,
        S_DEL_WR,
        S_INS_RD,
        S_INS_WR,
        S_WR_TGT,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    case (tpm_pkg::op_t'(s_op))
                        tpm_pkg::OP_LOOKUP: state_next = S_LK_RD;
                        tpm_pkg::OP_ADD, tpm_pkg::OP_DEL_MATCH,
                        tpm_pkg::OP_CHG_MATCH: state_next = S_MT_RD;
                        tpm_pkg::OP_DEL_ID, tpm_pkg::OP_CHG_ID: state_next = S_ID_RD;
                        default: begin
                            // unused op codes answer all zero
                            cmd.res_load   = 1'b1;
                            cmd.res_kind   = tpm_pkg::RK_PLAIN;
                            cmd.res_status = tpm_pkg::ST_OK;
                            state_next     = S_FIN;
                        end
                    endcase
                end
            end
            S_LK_RD: begin
                if (stat.idx_lt_n) begin
                    cmd.ram_re = 1'b1;
                    state_next = S_LK_CK;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = tpm_pkg::RK_MISS;
                    state_next   = S_FIN;
                end
            end
            S_LK_CK: begin
                if (stat.lk_match) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = tpm_pkg::RK_HIT;
                    state_next   = S_FIN;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_LK_RD;
                end
            end
            S_MT_RD, S_MT_CK: begin
                if (state_reg == S_MT_RD && stat.idx_lt_n) begin
                    cmd.ram_re = 1'b1;
                    state_next = S_MT_CK;
                end else if (state_reg == S_MT_CK && !stat.prio_gt && stat.mt_eq) begin
                    cmd.pos_from_idx = 1'b1;
                    case (stat.op)
                        tpm_pkg::OP_DEL_MATCH: state_next = S_DEL_RD;
                        tpm_pkg::OP_CHG_MATCH: state_next = S_WR_TGT;
                        default: begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = tpm_pkg::ST_EXISTS;
                            state_next     = S_FIN;
                        end
                    endcase
                end else if (state_reg == S_MT_CK && !stat.prio_gt) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_MT_RD;
                end else begin
                    // end of search without a match, idx is the insertion slot
                    cmd.pos_from_idx = 1'b1;
                    if (stat.op != tpm_pkg::OP_ADD) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = tpm_pkg::ST_NONE;
                        state_next     = S_FIN;
                    end else if (stat.full) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = tpm_pkg::ST_REFUSED;
                        state_next     = S_FIN;
                    end else begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_ID_RD;
                    end
                end
            end
            S_ID_RD: begin
                if (stat.req_id_zero && stat.op != tpm_pkg::OP_ADD) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = tpm_pkg::ST_NONE;
                    state_next     = S_FIN;
                end else if (stat.idx_lt_n) begin
                    cmd.ram_re = 1'b1;
                    state_next = S_ID_CK;
                end else if (stat.op == tpm_pkg::OP_ADD) begin
                    cmd.idx_load_n = 1'b1;
                    state_next     = S_INS_RD;
                end else begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = tpm_pkg::ST_NONE;
                    state_next     = S_FIN;
                end
            end
            S_ID_CK: begin
                if (!stat.id_eq) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_ID_RD;
                end else begin
                    case (stat.op)
                        tpm_pkg::OP_DEL_ID: begin
                            cmd.pos_from_idx = 1'b1;
                            state_next       = S_DEL_RD;
                        end
                        tpm_pkg::OP_CHG_ID: begin
                            cmd.pos_from_idx = 1'b1;
                            state_next       = S_WR_TGT;
                        end
                        default: begin
                            if (stat.req_id_zero) begin
                                // candidate taken, rescan with the next one
                                cmd.cand_inc = 1'b1;
                                cmd.idx_clr  = 1'b1;
                                state_next   = S_ID_RD;
                            end else begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = tpm_pkg::ST_REFUSED;
                                state_next     = S_FIN;
                            end
                        end
                    endcase
                end
            end
            S_DEL_RD: begin
                if (stat.idx_p1_lt_n) begin
                    cmd.ram_re = 1'b1;
                    cmd.rd_sel = tpm_pkg::RD_IDX_P1;
                    state_next = S_DEL_WR;
                end else begin
                    cmd.n_dec      = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = tpm_pkg::ST_OK;
                    state_next     = S_FIN;
                end
            end
            S_DEL_WR: begin
                cmd.ram_we  = 1'b1;
                cmd.wa_sel  = tpm_pkg::WA_IDX;
                cmd.wd_sel  = tpm_pkg::WD_MOVE;
                cmd.idx_inc = 1'b1;
                state_next  = S_DEL_RD;
            end
            S_INS_RD: begin
                if (stat.idx_gt_pos) begin
                    cmd.ram_re = 1'b1;
                    cmd.rd_sel = tpm_pkg::RD_IDX_M1;
                    state_next = S_INS_WR;
                end else begin
                    cmd.ram_we     = 1'b1;
                    cmd.wa_sel     = tpm_pkg::WA_POS;
                    cmd.wd_sel     = tpm_pkg::WD_NEW;
                    cmd.n_inc      = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_kind   = tpm_pkg::RK_ADDED;
                    cmd.res_status = tpm_pkg::ST_OK;
                    state_next     = S_FIN;
                end
            end
            S_INS_WR: begin
                cmd.ram_we  = 1'b1;
                cmd.wa_sel  = tpm_pkg::WA_IDX;
                cmd.wd_sel  = tpm_pkg::WD_MOVE;
                cmd.idx_dec = 1'b1;
                state_next  = S_INS_RD;
            end
            S_WR_TGT: begin
                cmd.ram_we     = 1'b1;
                cmd.wa_sel     = tpm_pkg::WA_POS;
                cmd.wd_sel     = tpm_pkg::WD_TGT;
                cmd.res_load   = 1'b1;
                cmd.res_status = tpm_pkg::ST_OK;
                state_next     = S_FIN;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/ternary_priority_match_table_unit.sv
// top level of the ternary priority match table
// lookup reads and checks the entries in turn, then the result goes to the output register
// add: a match scan, an identifier scan per candidate, a move of each entry above the slot, then the write
// delete and change: a scan by match or identifier, a move of each later entry on a delete, then the result
// one word in flight at a time; the entry ram, with one read and one write port, sets the pace
// reset (synchronous, aresetn low): table empty, miss target 0, key byte count 8
`timescale 1ns / 1ps

module ternary_priority_match_table_unit #(
    parameter int DEPTH       = 64,
    parameter int KEY_BITS    = 64,
    parameter int TARGET_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_op,
    input  logic [KEY_BITS-1:0] s_key,
    input  logic [KEY_BITS-1:0] s_key_mask,
    input  logic [31:0]         s_priority_req,
    input  logic [30:0]         s_entry_id,
    input  logic [31:0]         s_target_value,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic                m_hit,
    output logic [31:0]         m_target_out,
    output logic [30:0]         m_assigned_id,
    // register write channel, index 0 miss target, 1 key byte count
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    tpm_pkg::cmd_t  cmd;
    tpm_pkg::stat_t stat;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: walks the entries in priority order, reading and then checking each one
    tpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // entry ram, compare logic, fill count and output word register
    tpm_datapath #(
        .DEPTH       (DEPTH),
        .KEY_BITS    (KEY_BITS),
        .TARGET_BITS (TARGET_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_op           (s_op),
        .s_key          (s_key),
        .s_key_mask     (s_key_mask),
        .s_priority_req (s_priority_req),
        .s_entry_id     (s_entry_id),
        .s_target_value (s_target_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_hit          (m_hit),
        .m_target_out   (m_target_out),
        .m_assigned_id  (m_assigned_id),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

endmodule

### src/tpm_checker.sv
// port level checks for the ternary priority match table
`timescale 1ns / 1ps

module tpm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic        m_hit,
    input logic [31:0] m_target_out,
    input logic [30:0] m_assigned_id
);

    // nothing to deliver right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word shown after reset");

    // one word at a time: a taken request closes the input
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // a stalled result keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_hit)
            && $stable(m_target_out) && $stable(m_assigned_id))
        else $error("stalled result changed");

    // a lookup hit carries no status and no identifier
    a_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_status == 2'd0 && m_assigned_id == 31'd0)
        else $error("hit with add fields");

    // an assigned identifier only comes with a successful add
    a_aid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_assigned_id != 31'd0 |-> !m_hit && m_status == 2'd0
            && m_target_out == 32'd0)
        else $error("identifier on a failed add or lookup");

endmodule

bind ternary_priority_match_table_unit tpm_checker u_tpm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_hit         (m_hit),
    .m_target_out  (m_target_out),
    .m_assigned_id (m_assigned_id)
);
